/* rtl/pfw_pkg.sv */
// ----------------------------------------------------------------------------
// pfw_pkg: shared types and constants for the 6k wheel prime factorizer
// Holds the number width, result limit and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package pfw_pkg;
  localparam int NumWidth   = 32;
  localparam int MaxResults = 32;
  localparam int CntWidth   = $clog2(MaxResults + 1);

  typedef logic [NumWidth-1:0] num_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST,
    ST_EMIT,
    ST_TAIL
  } st_t;
endpackage
`default_nettype wire

/* rtl/pfw_divider.sv */
// ----------------------------------------------------------------------------
// pfw_divider: restoring radix-2 divider
// Computes quotient and remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pfw_divider import pfw_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  input  num_t dividend,
  input  num_t divisor,
  output logic done,
  output num_t quot,
  output num_t rem
);
  localparam int CW = $clog2(NumWidth + 1);

  num_t        q_r, q_nxt;
  logic [NumWidth:0] r_r, r_nxt;
  num_t        d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;
  logic [NumWidth:0] trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {r_r[NumWidth-1:0], q_r[NumWidth-1]};
    if (start) begin
      q_nxt   = dividend;
      r_nxt   = '0;
      cnt_nxt = CW'(NumWidth);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in next dividend bit, subtract if it fits
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NumWidth-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[NumWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) d_r <= divisor;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[NumWidth-1:0];
endmodule
`default_nettype wire

/* rtl/pfw_front.sv */
// ----------------------------------------------------------------------------
// pfw_front: input stage and two-entry queue
// Masks trivial numbers (0 and 1) and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pfw_front import pfw_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  num_t in_number,
  output logic q_valid,
  input  wire  q_pop,
  output num_t q_number
);
  num_t q_mem [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, keep;

  assign in_stall = (cnt_r == 2'd2);
  // drop 0 and 1: they give no beats
  assign keep = (in_number > num_t'(1));
  assign push = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_number = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) q_mem[wp_r] <= in_number;
  end
endmodule
`default_nettype wire

/* rtl/pfw_back.sv */
// ----------------------------------------------------------------------------
// pfw_back: trial-division sequencer
// Strips 2, 3 and the 6k-1 / 6k+1 divisors with a shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module pfw_back import pfw_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  q_valid,
  output logic q_pop,
  input  num_t q_number,
  output logic out_valid,
  input  wire  out_stall,
  output logic [31:0] out_factor,
  output logic out_last
);
  st_t  st_r, st_nxt;
  num_t rem_r, rem_nxt, d_r, d_nxt, quo_r, quo_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic alt_r, alt_nxt;         // 0: divisor 6k-1, 1: 6k+1
  logic wheel_r, wheel_nxt;     // in the wheel phase
  logic ov_r, ov_nxt;
  logic [31:0] of_r, of_nxt;
  logic ol_r, ol_nxt;
  logic div_start, div_done;
  num_t div_q, div_rem;
  logic full;

  pfw_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(rem_r), .divisor(d_r),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  assign full = (cnt_r == CntWidth'(MaxResults - 1));

  always_comb begin
    st_nxt = st_r; rem_nxt = rem_r; d_nxt = d_r; quo_nxt = quo_r;
    cnt_nxt = cnt_r; alt_nxt = alt_r; wheel_nxt = wheel_r;
    ov_nxt = ov_r; of_nxt = of_r; ol_nxt = ol_r;
    q_pop = 1'b0; div_start = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; rem_nxt = q_number; d_nxt = num_t'(2);
          cnt_nxt = '0; alt_nxt = 1'b0; wheel_nxt = 1'b0;
          st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // launch remaining / d
        div_start = 1'b1;
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          quo_nxt = div_q;
          if (wheel_r && !alt_r && div_q < d_r) st_nxt = ST_TAIL;
          else if (rem_r >= d_r && div_rem == '0) st_nxt = ST_EMIT;
          else st_nxt = ST_TEST;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; of_nxt = d_r[31:0];
          rem_nxt = quo_r;
          ol_nxt = full || (quo_r == num_t'(1));
          cnt_nxt = cnt_r + CntWidth'(1);
          st_nxt = ol_nxt ? ST_IDLE : ST_CHECK;
        end
      end
      ST_TEST: begin
        // advance to next divisor
        st_nxt = ST_CHECK;
        if (!wheel_r) begin
          if (d_r == num_t'(2)) d_nxt = num_t'(3);
          else begin d_nxt = num_t'(5); wheel_nxt = 1'b1; end
        end else if (!alt_r) begin
          d_nxt = d_r + num_t'(2); alt_nxt = 1'b1;
        end else begin
          d_nxt = d_r + num_t'(4); alt_nxt = 1'b0;
        end
      end
      ST_TAIL: begin
        if (rem_r == num_t'(1)) st_nxt = ST_IDLE;
        else if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; of_nxt = rem_r[31:0]; ol_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    rem_r <= rem_nxt; d_r <= d_nxt; quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    alt_r <= alt_nxt; wheel_r <= wheel_nxt; of_r <= of_nxt; ol_r <= ol_nxt;
  end

  assign out_valid  = ov_r;
  assign out_factor = of_r;
  assign out_last   = ol_r;
endmodule
`default_nettype wire

/* rtl/prime_factorizer_6k_wheel.sv */
// ----------------------------------------------------------------------------
// prime_factorizer_6k_wheel: trial-division prime factorizer
// Emits the prime factors of each number in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / in_number (32-bit unsigned).
//   Result channel: out_valid / out_stall / out_factor, out_last. One beat
//   per prime factor, with multiplicity; out_last marks the final factor.
//   Numbers 0 and 1 are accepted and produce no beats.
// Timing:
//   A front queue of two entries takes numbers while the back end works.
//   Each trial divisor costs one serial division plus the CHECK and TEST
//   sequencing states, so the time for a number grows with t, the wheel
//   divisors tried (up to about 21850 for a large prime). The shared
//   radix-2 divider dominates that time.
// Reset:
//   rst_n (synchronous, active low) empties the queue and idles the back end.
// Stall:
//   While out_stall holds, the pending beat holds and the sequencer waits before emitting its next beat.
// ----------------------------------------------------------------------------
`default_nettype none
module prime_factorizer_6k_wheel import pfw_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_number,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_factor,
  output logic        out_last
);
  logic q_valid, q_pop;
  num_t q_number;

  pfw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_number(in_number), .q_valid(q_valid), .q_pop(q_pop), .q_number(q_number)
  );

  pfw_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_number(q_number), .out_valid(out_valid), .out_stall(out_stall),
    .out_factor(out_factor), .out_last(out_last)
  );
endmodule
`default_nettype wire

/* rtl/pfw_checker.sv */
// ----------------------------------------------------------------------------
// pfw_checker: port-level checks for the factorizer
// Watches the result channel for handshake and value rules.
// ----------------------------------------------------------------------------
`default_nettype none
module pfw_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_factor,
  input wire        out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_factor))
    else $error("stalled beat changed");
  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_factor >= 32'd2)
    else $error("factor below two");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("beat after reset");
  a_asc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last ##1 out_valid
    |-> out_factor >= $past(out_factor))
    else $error("factors out of order");
endmodule
bind prime_factorizer_6k_wheel pfw_checker u_chk (.*);
`default_nettype wire

/* tb/prime_factorizer_6k_wheel_test.sv */
// ----------------------------------------------------------------------------
// prime_factorizer_6k_wheel_test: regression for the 6k wheel factorizer
// Drives numbers with bursty valid, stalls the result side on its own
// pattern, and checks every factor beat against a trial-division predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Factor list scoreboard: predicts the beats of each accepted number and
// matches them in order against the beats the block delivers.
class factor_scoreboard;
  typedef struct packed {
    logic [31:0] factor;
    logic        last;
  } factor_beat_t;

  factor_beat_t pending_factors[$];
  int unsigned  mismatches;
  int unsigned  numbers_seen;
  int unsigned  beats_checked;

  function new();
    mismatches    = 0;
    numbers_seen  = 0;
    beats_checked = 0;
  endfunction

  // Push one beat per prime factor, in ascending order, with multiplicity.
  function void note_number(logic [31:0] number);
    longint unsigned rest;
    longint unsigned divisor;
    int              count;
    factor_beat_t    beat;
    rest  = number;
    count = 0;
    numbers_seen++;
    if (rest <= 1) return;
    // strip 2, then 3, then walk the 6k-1 / 6k+1 wheel
    divisor = 2;
    while (count < pfw_pkg::MaxResults && rest > 1) begin
      if (divisor * divisor > rest) break;
      while (count < pfw_pkg::MaxResults && rest % divisor == 0) begin
        beat.factor = divisor[31:0];
        beat.last   = 1'b0;
        pending_factors.push_back(beat);
        count++;
        rest = rest / divisor;
      end
      if (divisor == 2) divisor = 3;
      else if (divisor == 3) divisor = 5;
      else if (divisor % 6 == 5) divisor = divisor + 2;
      else divisor = divisor + 4;
    end
    // leftover above one is the largest prime factor
    if (count < pfw_pkg::MaxResults && rest > 1) begin
      beat.factor = rest[31:0];
      beat.last   = 1'b0;
      pending_factors.push_back(beat);
      count++;
    end
    if (count > 0) pending_factors[pending_factors.size()-1].last = 1'b1;
  endfunction

  function void check_beat(logic [31:0] factor, logic last);
    factor_beat_t want;
    if (pending_factors.size() == 0) begin
      report(0, 0, factor, last, "beat with nothing expected");
      return;
    end
    want = pending_factors.pop_front();
    beats_checked++;
    if (want.factor !== factor || want.last !== last)
      report(want.factor, want.last, factor, last, "factor beat mismatch");
  endfunction

  function void report(logic [31:0] exp_f, logic exp_l, logic [31:0] act_f,
                       logic act_l, string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected factor %0d last %0b, got factor %0d last %0b",
               $realtime, what, exp_f, exp_l, act_f, act_l);
  endfunction
endclass

module prime_factorizer_6k_wheel_test;
  // A number whose smallest factor sits near 2^16 walks the whole wheel
  // with no beat; hold the limit well above that walk.
  localparam int IdleLimit  = 3000000;
  localparam int DrainLimit = 4 * IdleLimit;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_number;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_factor;
  logic        out_last;

  factor_scoreboard factor_sb;
  int unsigned      idle_cycles;
  int unsigned      burst_left;
  bit               stall_free;
  bit               stimulus_done;

  prime_factorizer_6k_wheel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_number (in_number),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_factor(out_factor),
    .out_last  (out_last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Monitor: sample both channels at the rising edge, before the block's
  // registers update. Count cycles with no beat for the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) factor_sb.note_number(in_number);
      if (out_valid && !out_stall) factor_sb.check_beat(out_factor, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat for %0d cycles", IdleLimit);
        $display("prime_factorizer_6k_wheel regression: fail");
        $finish;
      end
    end
  end

  // Result-side stall: alternate between clean stretches and random stalls
  // so stalls land on every phase of the factor stream.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_free <= ~stall_free;
      out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 2) == 0);
    end
  end

  // Offer one number and hold it until it is taken. Between bursts drop
  // valid for a random gap.
  task automatic send_number(logic [31:0] number);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 6);
    end
    in_valid  = 1'b1;
    in_number = number;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  // Smooth numbers keep the wheel walk short while still filling high bits;
  // a bounded cofactor adds a larger prime now and then.
  function automatic logic [31:0] make_smooth_number();
    longint unsigned value;
    longint unsigned pick;
    value = 1;
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 5))
        0: pick = 2;
        1: pick = 3;
        2: pick = $urandom_range(2, 40);
        3: pick = $urandom_range(2, 400);
        4: pick = $urandom_range(2, 3000);
        default: pick = $urandom_range(2, 150000);
      endcase
      if (value * pick <= 64'hFFFF_FFFF) value = value * pick;
    end
    return value[31:0];
  endfunction

  initial begin
    logic [31:0] directed_numbers[$];
    logic [31:0] number;
    int unsigned wait_cycles;

    factor_sb     = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_number     = '0;
    out_stall     = 1'b0;
    idle_cycles   = 0;
    burst_left    = 0;
    stall_free    = 1'b1;
    stimulus_done = 1'b0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero and one, small primes, prime powers, both ends of the
    // range, all bits set, and a prime near 2^20 to walk the wheel.
    directed_numbers = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7,
                         32'd25, 32'd35, 32'd49, 32'd77, 32'd121, 32'd143,
                         32'h8000_0000, 32'hFFFF_FFFF, 32'd3486784401,
                         32'd1048573, 32'd65521, 32'd4294836225,
                         32'd2310, 32'd30030, 32'd1, 32'd0, 32'hAAAA_AAAA,
                         32'h5555_5554};
    foreach (directed_numbers[i]) send_number(directed_numbers[i]);

    // Random: mostly smooth numbers, with some zero and one noise mixed in.
    repeat (75) begin
      if ($urandom_range(0, 19) == 0) number = $urandom_range(0, 1);
      else number = make_smooth_number();
      send_number(number);
    end
    in_valid = 1'b0;
    stimulus_done = 1'b1;

    // Drain, then idle a while to catch stray beats.
    wait_cycles = 0;
    while (factor_sb.pending_factors.size() != 0) begin
      @(negedge clk);
      wait_cycles++;
      if (wait_cycles > DrainLimit) begin
        $display("prime_factorizer_6k_wheel regression: fail");
        $finish;
      end
    end
    repeat (200) @(negedge clk);

    $display("covered %0d numbers and %0d factor beats under bursty input",
             factor_sb.numbers_seen, factor_sb.beats_checked);
    $display("and random result stalls; %0d mismatches", factor_sb.mismatches);
    if (factor_sb.mismatches == 0 && factor_sb.pending_factors.size() == 0) begin
      $display("prime_factorizer_6k_wheel regression: pass");
    end else begin
      $display("prime_factorizer_6k_wheel regression: fail");
    end
    $finish;
  end
endmodule

/* prime_factorizer_6k_wheel.f */
rtl/pfw_pkg.sv
rtl/pfw_divider.sv
rtl/pfw_front.sv
rtl/pfw_back.sv
rtl/prime_factorizer_6k_wheel.sv
rtl/pfw_checker.sv
tb/prime_factorizer_6k_wheel_test.sv
